@@ sv/hcr_pkg.sv @@
// shared constants, types and helpers of the hard collision response block
`timescale 1ns / 1ps
`default_nettype none
package hcr_pkg;

  localparam int unsigned VEC_W      = 32;
  localparam int unsigned IN_W       = 12 * VEC_W;
  localparam int unsigned OUT_W      = 6 * VEC_W;
  localparam int unsigned REL_W      = VEC_W + 1;
  localparam int unsigned DIR_W      = 14;
  localparam int unsigned QUO_W      = 33;
  localparam int unsigned DEN_W      = 30;
  localparam int unsigned NUM_W      = 62;
  localparam int unsigned DIV_STEPS  = 3;
  localparam int unsigned DIV_STAGES = QUO_W / DIV_STEPS;

  localparam logic [1:0] OUT_NONE    = 2'd0;
  localparam logic [1:0] OUT_STUCK   = 2'd1;
  localparam logic [1:0] OUT_REFLECT = 2'd2;

  localparam logic [7:0] CFG_ELASTICITY = 8'd0;
  localparam logic [7:0] CFG_DAMPING    = 8'd1;
  localparam logic [7:0] CFG_HALT       = 8'd2;

  localparam logic [15:0] Q15_ONE = 16'd32768;

  typedef struct packed {
    logic [16:0] factor;
    logic [15:0] damp;
    logic [61:0] halt_sq;
  } cfg_t;

  typedef struct packed {
    logic [2:0][VEC_W-1:0] np;
    logic [2:0][VEC_W-1:0] vel;
    logic [2:0][VEC_W-1:0] surf;
    logic [2:0][REL_W-1:0] rel;
    logic [1:0]            outcome;
  } side_t;

  function automatic logic [31:0] sat32(input logic signed [37:0] x);
    logic [31:0] res;
    if (x > 38'sd2147483647) res = 32'h7fff_ffff;
    else if (x < -38'sd2147483648) res = 32'h8000_0000;
    else res = x[31:0];
    return res;
  endfunction

endpackage
`default_nettype wire

@@ sv/hard_collision_response.sv @@
// top level of the hard collision response pipeline
//
//   port group | dir | payload
//   in_*       | in  | tdata: pos xyz, vel xyz, pen xyz, surf_vel xyz
//   out_*      | out | tdata: new_pos xyz, new_vel xyz; tuser: outcome
//   cfg_*      | in  | cfg_index, cfg_data register writes
//
// one beat in and one beat out per cycle while the output is not stalled;
// 6 front stages, 11 divider stages of 3 quotient bits, 3 back stages
// the divider lanes set the depth; the whole pipe advances when the
// result register is empty or taken, and holds otherwise
// rst_n clears valid bits and loads the register reset values
`timescale 1ns / 1ps
`default_nettype none
module hard_collision_response (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [383:0] in_tdata,   // pos_x,y,z, vel_x,y,z, pen_x,y,z, surf_vel_x,y,z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata,  // new_pos_x,y,z, new_vel_x,y,z
  output logic [1:0]   out_tuser,  // outcome
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic [15:0] el_r;
  logic [15:0] dmp_r;
  logic [30:0] halt_r;
  logic [61:0] hsq_r;
  hcr_pkg::cfg_t cfg;
  logic en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      el_r   <= 16'd13107;
      dmp_r  <= 16'd1638;
      halt_r <= 31'd11;
      hsq_r  <= 62'd121;
    end else begin
      hsq_r <= 62'(halt_r) * 62'(halt_r);
      if (cfg_valid) begin
        unique case (cfg_index)
          hcr_pkg::CFG_ELASTICITY: el_r   <= cfg_data[15:0];
          hcr_pkg::CFG_DAMPING:    dmp_r  <= cfg_data[15:0];
          hcr_pkg::CFG_HALT:       halt_r <= cfg_data[30:0];
          default: ;
        endcase
      end
    end
  end

  assign cfg.factor  = 17'(hcr_pkg::Q15_ONE) + 17'(el_r);
  assign cfg.damp    = (dmp_r > hcr_pkg::Q15_ONE) ? hcr_pkg::Q15_ONE : dmp_r;
  assign cfg.halt_sq = hsq_r;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic                          f_valid;
  logic [2:0][hcr_pkg::NUM_W-1:0] f_num;
  logic [2:0]                    f_neg;
  logic [hcr_pkg::DEN_W-1:0]     f_den;
  hcr_pkg::side_t                f_side;

  hcr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_data   (in_tdata),
    .cfg       (cfg),
    .out_valid (f_valid),
    .num       (f_num),
    .neg       (f_neg),
    .den       (f_den),
    .side      (f_side)
  );

  logic [2:0][hcr_pkg::QUO_W-1:0] quo;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    hcr_div u_div (
      .clk (clk),
      .en  (en),
      .num (f_num[i]),
      .den (f_den),
      .quo (quo[i])
    );
  end

  // side data travelling beside the divider lanes
  logic           dv_r   [hcr_pkg::DIV_STAGES];
  logic [2:0]     dneg_r [hcr_pkg::DIV_STAGES];
  hcr_pkg::side_t dside_r [hcr_pkg::DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < hcr_pkg::DIV_STAGES; k++) dv_r[k] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= f_valid;
      for (int k = 1; k < hcr_pkg::DIV_STAGES; k++) dv_r[k] <= dv_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dneg_r[0]  <= f_neg;
      dside_r[0] <= f_side;
      for (int k = 1; k < hcr_pkg::DIV_STAGES; k++) begin
        dneg_r[k]  <= dneg_r[k-1];
        dside_r[k] <= dside_r[k-1];
      end
    end
  end

  hcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dv_r[hcr_pkg::DIV_STAGES-1]),
    .quo       (quo),
    .neg       (dneg_r[hcr_pkg::DIV_STAGES-1]),
    .side      (dside_r[hcr_pkg::DIV_STAGES-1]),
    .cfg       (cfg),
    .out_valid (out_tvalid),
    .out_data  (out_tdata),
    .out_kind  (out_tuser)
  );

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == hcr_pkg::OUT_NONE || out_tuser == hcr_pkg::OUT_STUCK ||
                    out_tuser == hcr_pkg::OUT_REFLECT))
    else $error("illegal outcome on result beat");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while pipeline stalled");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

endmodule
`default_nettype wire

@@ sv/hcr_front.sv @@
// contact test, sticking test, direction normalising and projection numerator
`timescale 1ns / 1ps
`default_nettype none
module hcr_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [hcr_pkg::IN_W-1:0]    in_data,
  input  hcr_pkg::cfg_t               cfg,
  output logic                        out_valid,
  output logic [2:0][hcr_pkg::NUM_W-1:0] num,
  output logic [2:0]                  neg,
  output logic [hcr_pkg::DEN_W-1:0]   den,
  output hcr_pkg::side_t              side
);

  // stage 1
  logic              v1_r;
  logic [31:0]       p1_r [3];
  logic [31:0]       pn1_r [3];
  logic [31:0]       vel1_r [3];
  logic [31:0]       n1_r [3];
  logic [31:0]       nm1_r [3];
  logic [31:0]       s1_r [3];
  logic [32:0]       r1_r [3];
  logic [31:0]       m1_r;
  logic [31:0]       p_in [3];
  logic [31:0]       v_in [3];
  logic [31:0]       n_in [3];
  logic [31:0]       s_in [3];
  logic [31:0]       pn_nxt [3];
  logic [31:0]       nm_nxt [3];
  logic [32:0]       r_nxt [3];
  logic [31:0]       m_nxt;

  always_comb begin
    m_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      p_in[i]   = in_data[i*hcr_pkg::VEC_W +: hcr_pkg::VEC_W];
      v_in[i]   = in_data[(3+i)*hcr_pkg::VEC_W +: hcr_pkg::VEC_W];
      n_in[i]   = in_data[(6+i)*hcr_pkg::VEC_W +: hcr_pkg::VEC_W];
      s_in[i]   = in_data[(9+i)*hcr_pkg::VEC_W +: hcr_pkg::VEC_W];
      r_nxt[i]  = {s_in[i][31], s_in[i]} - {v_in[i][31], v_in[i]};
      pn_nxt[i] = hcr_pkg::sat32(38'($signed(p_in[i])) - 38'($signed(n_in[i])));
      nm_nxt[i] = n_in[i][31] ? 32'(-n_in[i]) : n_in[i];
      if (nm_nxt[i] > m_nxt) m_nxt = nm_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r   <= p_in;
      pn1_r  <= pn_nxt;
      vel1_r <= v_in;
      n1_r   <= n_in;
      nm1_r  <= nm_nxt;
      s1_r   <= s_in;
      r1_r   <= r_nxt;
      m1_r   <= m_nxt;
    end
  end

  // stage 2
  logic              v2_r;
  logic signed [64:0] prod2_r [3];
  logic [61:0]       sq2_r [3];
  logic              big2_r;
  logic [3:0]        bl2_r [4];
  logic [31:0]       p2_r [3];
  logic [31:0]       pn2_r [3];
  logic [31:0]       vel2_r [3];
  logic [31:0]       n2_r [3];
  logic [31:0]       nm2_r [3];
  logic [31:0]       s2_r [3];
  logic [32:0]       r2_r [3];
  logic signed [64:0] prod_nxt [3];
  logic [61:0]       sq_nxt [3];
  logic [32:0]       rm [3];
  logic              big_nxt;
  logic [3:0]        bl_nxt [4];

  always_comb begin
    big_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i] = $signed(r1_r[i]) * $signed(n1_r[i]);
      rm[i]       = r1_r[i][32] ? 33'(-r1_r[i]) : r1_r[i];
      sq_nxt[i]   = 62'(rm[i][30:0]) * 62'(rm[i][30:0]);
      if (rm[i][32] || rm[i][31]) big_nxt = 1'b1;
    end
    for (int b = 0; b < 4; b++) begin
      bl_nxt[b] = '0;
      for (int k = 0; k < 8; k++) begin
        if (m1_r[8*b+k]) bl_nxt[b] = 4'(k + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod2_r <= prod_nxt;
      sq2_r   <= sq_nxt;
      big2_r  <= big_nxt;
      bl2_r   <= bl_nxt;
      p2_r    <= p1_r;
      pn2_r   <= pn1_r;
      vel2_r  <= vel1_r;
      n2_r    <= n1_r;
      nm2_r   <= nm1_r;
      s2_r    <= s1_r;
      r2_r    <= r1_r;
    end
  end

  // stage 3
  logic              v3_r;
  hcr_pkg::side_t    side3_r;
  logic signed [14:0] q3_r [3];
  logic [13:0]       qm3_r [3];
  hcr_pkg::side_t    side_nxt;
  logic signed [66:0] dot;
  logic [63:0]       rr;
  logic              contact;
  logic              stuck;
  logic [5:0]        blen;
  logic [13:0]       qm_nxt [3];
  logic signed [14:0] q_nxt [3];

  always_comb begin
    dot = 67'(prod2_r[0]) + 67'(prod2_r[1]) + 67'(prod2_r[2]);
    rr  = 64'(sq2_r[0]) + 64'(sq2_r[1]) + 64'(sq2_r[2]);
    contact = dot[66];
    stuck   = !big2_r && (rr < 64'(cfg.halt_sq));
    if (bl2_r[3] != '0) blen = 6'(bl2_r[3]) + 6'd24;
    else if (bl2_r[2] != '0) blen = 6'(bl2_r[2]) + 6'd16;
    else if (bl2_r[1] != '0) blen = 6'(bl2_r[1]) + 6'd8;
    else blen = 6'(bl2_r[0]);
    for (int i = 0; i < 3; i++) begin
      if (blen > 6'(hcr_pkg::DIR_W)) qm_nxt[i] = 14'(nm2_r[i] >> (blen - 6'(hcr_pkg::DIR_W)));
      else qm_nxt[i] = 14'(nm2_r[i] << (6'(hcr_pkg::DIR_W) - blen));
      q_nxt[i] = n2_r[i][31] ? -$signed({1'b0, qm_nxt[i]}) : $signed({1'b0, qm_nxt[i]});
      side_nxt.np[i]   = contact ? pn2_r[i] : p2_r[i];
      side_nxt.vel[i]  = vel2_r[i];
      side_nxt.surf[i] = s2_r[i];
      side_nxt.rel[i]  = r2_r[i];
    end
    if (!contact) side_nxt.outcome = hcr_pkg::OUT_NONE;
    else if (stuck) side_nxt.outcome = hcr_pkg::OUT_STUCK;
    else side_nxt.outcome = hcr_pkg::OUT_REFLECT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3_r <= side_nxt;
      q3_r    <= q_nxt;
      qm3_r   <= qm_nxt;
    end
  end

  // stage 4
  logic              v4_r;
  hcr_pkg::side_t    side4_r;
  logic signed [47:0] rq4_r [3];
  logic [27:0]       qsq4_r [3];
  logic [13:0]       qm4_r [3];
  logic [2:0]        qn4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4_r <= side3_r;
      for (int i = 0; i < 3; i++) begin
        rq4_r[i]  <= $signed(side3_r.rel[i]) * q3_r[i];
        qsq4_r[i] <= 28'(qm3_r[i]) * 28'(qm3_r[i]);
        qm4_r[i]  <= qm3_r[i];
        qn4_r[i]  <= q3_r[i][14];
      end
    end
  end

  // stage 5
  logic              v5_r;
  hcr_pkg::side_t    side5_r;
  logic signed [49:0] dq5_r;
  logic [29:0]       qq5_r;
  logic [13:0]       qm5_r [3];
  logic [2:0]        qn5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side5_r <= side4_r;
      dq5_r   <= 50'(rq4_r[0]) + 50'(rq4_r[1]) + 50'(rq4_r[2]);
      qq5_r   <= 30'(qsq4_r[0]) + 30'(qsq4_r[1]) + 30'(qsq4_r[2]);
      qm5_r   <= qm4_r;
      qn5_r   <= qn4_r;
    end
  end

  // stage 6
  logic              v6_r;
  hcr_pkg::side_t    side6_r;
  logic [2:0][hcr_pkg::NUM_W-1:0] num6_r;
  logic [2:0]        neg6_r;
  logic [hcr_pkg::DEN_W-1:0] den6_r;
  logic [49:0]       dqm;

  assign dqm = dq5_r[49] ? 50'(-dq5_r) : dq5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side6_r <= side5_r;
      den6_r  <= qq5_r;
      for (int i = 0; i < 3; i++) begin
        num6_r[i] <= 62'(dqm[47:0]) * 62'(qm5_r[i]);
        neg6_r[i] <= dq5_r[49] ^ qn5_r[i];
      end
    end
  end

  assign out_valid = v6_r;
  assign num       = num6_r;
  assign neg       = neg6_r;
  assign den       = den6_r;
  assign side      = side6_r;

endmodule
`default_nettype wire

@@ sv/hcr_div.sv @@
// pipelined restoring divider lane for the projection quotient
`timescale 1ns / 1ps
`default_nettype none
module hcr_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [hcr_pkg::NUM_W-1:0]   num,
  input  logic [hcr_pkg::DEN_W-1:0]   den,
  output logic [hcr_pkg::QUO_W-1:0]   quo
);

  logic [hcr_pkg::DEN_W-1:0] rem_r [hcr_pkg::DIV_STAGES];
  logic [hcr_pkg::QUO_W-1:0] low_r [hcr_pkg::DIV_STAGES];
  logic [hcr_pkg::QUO_W-1:0] quo_r [hcr_pkg::DIV_STAGES];
  logic [hcr_pkg::DEN_W-1:0] den_r [hcr_pkg::DIV_STAGES];

  for (genvar k = 0; k < hcr_pkg::DIV_STAGES; k++) begin : g_stage
    logic [hcr_pkg::DEN_W-1:0] rem_in;
    logic [hcr_pkg::QUO_W-1:0] low_in;
    logic [hcr_pkg::QUO_W-1:0] quo_in;
    logic [hcr_pkg::DEN_W-1:0] den_in;
    logic [hcr_pkg::DEN_W-1:0] rem_nxt;
    logic [hcr_pkg::QUO_W-1:0] low_nxt;
    logic [hcr_pkg::QUO_W-1:0] quo_nxt;
    logic [hcr_pkg::DEN_W:0]   trial;

    if (k == 0) begin : g_head
      assign rem_in = hcr_pkg::DEN_W'(num[hcr_pkg::NUM_W-1:hcr_pkg::QUO_W]);
      assign low_in = num[hcr_pkg::QUO_W-1:0];
      assign quo_in = '0;
      assign den_in = den;
    end else begin : g_body
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign quo_in = quo_r[k-1];
      assign den_in = den_r[k-1];
    end

    always_comb begin
      rem_nxt = rem_in;
      low_nxt = low_in;
      quo_nxt = quo_in;
      trial   = '0;
      for (int s = 0; s < hcr_pkg::DIV_STEPS; s++) begin
        trial   = {rem_nxt, low_nxt[hcr_pkg::QUO_W-1]};
        low_nxt = {low_nxt[hcr_pkg::QUO_W-2:0], 1'b0};
        if (trial >= {1'b0, den_in}) begin
          rem_nxt = hcr_pkg::DEN_W'(trial - {1'b0, den_in});
          quo_nxt = {quo_nxt[hcr_pkg::QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[hcr_pkg::DEN_W-1:0];
          quo_nxt = {quo_nxt[hcr_pkg::QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        low_r[k] <= low_nxt;
        quo_r[k] <= quo_nxt;
        den_r[k] <= den_in;
      end
    end
  end

  assign quo = quo_r[hcr_pkg::DIV_STAGES-1];

endmodule
`default_nettype wire

@@ sv/hcr_back.sv @@
// restitution and friction scaling, final sum, saturation and result register
`timescale 1ns / 1ps
`default_nettype none
module hcr_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [2:0][hcr_pkg::QUO_W-1:0] quo,
  input  logic [2:0]                    neg,
  input  hcr_pkg::side_t                side,
  input  hcr_pkg::cfg_t                 cfg,
  output logic                          out_valid,
  output logic [hcr_pkg::OUT_W-1:0]     out_data,
  output logic [1:0]                    out_kind
);

  // stage 1: tangential part
  logic           v1_r;
  hcr_pkg::side_t side1_r;
  logic [32:0]    qm1_r [3];
  logic [2:0]     qn1_r;
  logic [33:0]    tm1_r [3];
  logic [2:0]     tn1_r;
  logic signed [34:0] rn [3];
  logic signed [34:0] t [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rn[i] = neg[i] ? -$signed({2'b0, quo[i]}) : $signed({2'b0, quo[i]});
      t[i]  = 35'($signed(side.rel[i])) - rn[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= side;
      for (int i = 0; i < 3; i++) begin
        qm1_r[i] <= quo[i];
        qn1_r[i] <= neg[i];
        tm1_r[i] <= t[i][34] ? 34'(-t[i]) : t[i][33:0];
        tn1_r[i] <= t[i][34];
      end
    end
  end

  // stage 2: q2.15 restitution and q1.15 friction scaling
  logic           v2_r;
  hcr_pkg::side_t side2_r;
  logic [34:0]    a2_r [3];
  logic [34:0]    b2_r [3];
  logic [2:0]     an2_r;
  logic [2:0]     bn2_r;
  logic [49:0]    pa [3];
  logic [49:0]    pb [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa[i] = 50'(qm1_r[i]) * 50'(cfg.factor);
      pb[i] = 50'(tm1_r[i]) * 50'(cfg.damp);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2_r <= side1_r;
      an2_r   <= qn1_r;
      bn2_r   <= tn1_r;
      for (int i = 0; i < 3; i++) begin
        a2_r[i] <= pa[i][49:15];
        b2_r[i] <= pb[i][49:15];
      end
    end
  end

  // stage 3: sum, saturate, select
  logic                      v3_r;
  logic [hcr_pkg::OUT_W-1:0] data3_r;
  logic [1:0]                kind3_r;
  logic [hcr_pkg::OUT_W-1:0] data_nxt;
  logic signed [37:0]        sa [3];
  logic signed [37:0]        sb [3];
  logic [31:0]               nv [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sa[i] = an2_r[i] ? -$signed({3'b0, a2_r[i]}) : $signed({3'b0, a2_r[i]});
      sb[i] = bn2_r[i] ? -$signed({3'b0, b2_r[i]}) : $signed({3'b0, b2_r[i]});
      unique case (side2_r.outcome)
        hcr_pkg::OUT_REFLECT:
          nv[i] = hcr_pkg::sat32(38'($signed(side2_r.vel[i])) + sa[i] + sb[i]);
        hcr_pkg::OUT_STUCK: nv[i] = side2_r.surf[i];
        default: nv[i] = side2_r.vel[i];
      endcase
      data_nxt[i*hcr_pkg::VEC_W +: hcr_pkg::VEC_W]     = side2_r.np[i];
      data_nxt[(3+i)*hcr_pkg::VEC_W +: hcr_pkg::VEC_W] = nv[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data3_r <= data_nxt;
      kind3_r <= side2_r.outcome;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = data3_r;
  assign out_kind  = kind3_r;

endmodule
`default_nettype wire

@@ verif/hard_collision_response_tb.sv @@
// self-checking testbench of the hard collision response block: directed table then random contacts
`timescale 1ns / 1ps
module hard_collision_response_tb;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [383:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [191:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  always #2 clk = ~clk;

  hard_collision_response u_dut (.*);

  typedef struct packed {
    logic [191:0] vec;
    logic [1:0]   outcome;
  } response_t;

  typedef struct {
    logic [383:0] contact;
    logic         has_exp;
    logic [1:0]   exp_outcome;
  } row_t;

  logic [15:0] elast_q;
  logic [15:0] damp_q;
  logic [30:0] halt_q;
  response_t   resp_q[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          in_on = 1'b1;
  bit          out_on = 1'b1;
  int          in_gap_left = 0;
  int          out_gap_left = 0;

  function automatic longint unsigned mag64(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic longint apply_sign(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint scale_by_q15(longint x, longint unsigned f);
    return apply_sign((mag64(x) * f) >> 15, x < 0);
  endfunction

  function automatic logic [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return 32'h7fff_ffff;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  function automatic response_t predict_contact(logic [383:0] c);
    longint p[3], v[3], n[3], s[3], r[3], np[3], nv[3], q[3];
    logic signed [127:0] dot;
    longint unsigned rr, h, m, f, dmp, qq_u;
    longint dq, qq, rn;
    int rs, ls;
    bit bounded;
    response_t res;
    logic [1:0] oc;
    dot = 0;
    oc = hcr_pkg::OUT_NONE;
    for (int i = 0; i < 3; i++) begin
      p[i] = longint'($signed(c[32*i +: 32]));
      v[i] = longint'($signed(c[32*(3+i) +: 32]));
      n[i] = longint'($signed(c[32*(6+i) +: 32]));
      s[i] = longint'($signed(c[32*(9+i) +: 32]));
      r[i] = s[i] - v[i];
      dot += 128'(r[i]) * 128'(n[i]);
      np[i] = p[i];
      nv[i] = v[i];
    end
    if (dot < 0) begin
      bounded = 1'b1;
      rr = 0;
      h = 64'(halt_q);
      for (int i = 0; i < 3; i++) begin
        np[i] = p[i] - n[i];
        if (mag64(r[i]) >= 64'h8000_0000) bounded = 1'b0;
        else rr += mag64(r[i]) * mag64(r[i]);
      end
      if (bounded && rr < h * h) begin
        oc = hcr_pkg::OUT_STUCK;
        for (int i = 0; i < 3; i++) nv[i] = s[i];
      end else begin
        oc = hcr_pkg::OUT_REFLECT;
        f = 64'(hcr_pkg::Q15_ONE) + 64'(elast_q);
        dmp = damp_q > hcr_pkg::Q15_ONE ? 64'(hcr_pkg::Q15_ONE) : 64'(damp_q);
        m = 0; rs = 0; ls = 0; dq = 0; qq = 0;
        for (int i = 0; i < 3; i++) if (mag64(n[i]) > m) m = mag64(n[i]);
        while ((m >> rs) >= 16384) rs++;
        while (m != 0 && (((m >> rs) << ls) < 8192)) ls++;
        for (int i = 0; i < 3; i++) begin
          q[i] = apply_sign((mag64(n[i]) >> rs) << ls, n[i] < 0);
          dq += r[i] * q[i];
          qq += q[i] * q[i];
        end
        qq_u = 64'(qq);
        for (int i = 0; i < 3; i++) begin
          rn = 0;
          if (qq > 0) rn = apply_sign(mag64(dq) * mag64(q[i]) / qq_u, (dq < 0) != (q[i] < 0));
          nv[i] = v[i] + scale_by_q15(rn, f) + scale_by_q15(r[i] - rn, dmp);
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      res.vec[32*i +: 32] = clamp32(np[i]);
      res.vec[32*(3+i) +: 32] = clamp32(nv[i]);
    end
    res.outcome = oc;
    return res;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
  endfunction

  // result checking at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (resp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", out_tdata);
        end else begin
          response_t e;
          e = resp_q.pop_front();
          if (out_tdata !== e.vec || out_tuser !== e.outcome) begin
            mismatches++;
            if (mismatches <= 10) begin
              for (int i = 0; i < 6; i++)
                if (out_tdata[32*i +: 32] !== e.vec[32*i +: 32])
                  $display("field %0d exp %h got %h", i, e.vec[32*i +: 32], out_tdata[32*i +: 32]);
              if (out_tuser !== e.outcome)
                $display("outcome exp %0d got %0d", e.outcome, out_tuser);
            end
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 5000) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (out_gap_left > 0) begin
      out_gap_left--;
      out_tready <= 1'b0;
    end else if (!out_on) begin
      out_tready <= 1'b1;
    end else begin
      if ($urandom_range(0, 5) == 0) out_gap_left = gap_len();
      out_tready <= (out_gap_left == 0);
    end
    if ($urandom_range(0, 299) == 0) out_on = !out_on;
  end

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      hcr_pkg::CFG_ELASTICITY: elast_q = val[15:0];
      hcr_pkg::CFG_DAMPING:    damp_q = val[15:0];
      hcr_pkg::CFG_HALT:       halt_q = val[30:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (resp_q.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic send_contact(logic [383:0] c, bit has_exp, logic [1:0] exp_oc);
    response_t e;
    int gap;
    gap = in_on ? gap_len() : 0;
    if ($urandom_range(0, 3) != 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata <= c;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    e = predict_contact(c);
    if (has_exp && e.outcome !== exp_oc) begin
      mismatches++;
      if (mismatches <= 10) $display("table outcome %0d, predicted %0d", exp_oc, e.outcome);
    end
    resp_q.push_back(e);
    @(negedge clk);
    if ($urandom_range(0, 199) == 0) in_on = !in_on;
  endtask

  task automatic idle_input();
    in_tvalid <= 1'b0;
  endtask

  function automatic logic [383:0] make_contact(logic [31:0] px, logic [31:0] vx,
      logic [31:0] nx, logic [31:0] sx, logic [31:0] vy, logic [31:0] ny);
    logic [383:0] c;
    c = '0;
    c[31:0] = px; c[127:96] = vx; c[159:128] = vy;
    c[223:192] = nx; c[255:224] = ny; c[319:288] = sx;
    return c;
  endfunction

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 64) - 32;
      3: return $urandom & 32'h000f_ffff ^ ({32{$urandom_range(0, 1) == 1}});
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [383:0] rnd_contact();
    logic [383:0] c;
    int style;
    for (int i = 0; i < 12; i++) c[32*i +: 32] = rnd_word();
    style = $urandom_range(0, 9);
    // mostly approaching contacts: velocity along the penetration
    if (style < 6) begin
      for (int i = 0; i < 3; i++) begin
        c[32*(6+i) +: 32] = $signed($urandom_range(0, 2000000)) - 1000000;
        c[32*(9+i) +: 32] = $signed($urandom_range(0, 2000)) - 1000;
        c[32*(3+i) +: 32] = $signed(c[32*(6+i) +: 32]) * $urandom_range(0, 3)
                            + ($signed($urandom_range(0, 200)) - 100);
      end
    end else if (style < 8) begin
      for (int i = 0; i < 3; i++) begin
        c[32*(9+i) +: 32] = $urandom_range(0, 8) - 4;
        c[32*(3+i) +: 32] = $urandom_range(0, 8) - 4;
      end
    end
    return c;
  endfunction

  row_t table_rows[$];

  initial begin
    row_t rw;
    elast_q = 16'd13107;
    damp_q = 16'd1638;
    halt_q = 31'd11;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    out_gap_left = 0;

    // zero or receding pen: separating; stuck when slow; reflect when fast; extremes
    rw.has_exp = 1; rw.exp_outcome = hcr_pkg::OUT_NONE;
    rw.contact = '0; table_rows.push_back(rw);
    rw.contact = make_contact(32'h7fff_ffff, 32'h100, 32'h0, 32'h0, 0, 0); table_rows.push_back(rw);
    rw.contact = make_contact(32'h1, 32'h10, 32'hffff_fff0, 32'h0, 0, 0); table_rows.push_back(rw);
    rw.exp_outcome = hcr_pkg::OUT_STUCK;
    rw.contact = make_contact(32'h5, 32'h3, 32'h40, 32'h0, 0, 0); table_rows.push_back(rw);
    rw.contact = make_contact(32'h8000_0000, 32'h1, 32'h1, 32'h0, 0, 0); table_rows.push_back(rw);
    rw.exp_outcome = hcr_pkg::OUT_REFLECT;
    rw.contact = make_contact(32'h0, 32'h0001_0000, 32'h0000_1000, 32'h0, 32'h0002_0000, 0);
    table_rows.push_back(rw);
    rw.contact = make_contact(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                              32'h8000_0000, 32'h7fff_ffff);
    table_rows.push_back(rw);
    rw.contact = make_contact(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                              32'h7fff_ffff, 32'h1);
    table_rows.push_back(rw);
    rw.contact = make_contact(32'h0, 32'h1234_5678, 32'h0000_0003, 32'hedcb_a988, 32'h0, 32'hffff_fffd);
    table_rows.push_back(rw);
    rw.has_exp = 0;
    for (int k = 0; k < 6; k++) begin
      rw.contact = '1 ^ (384'(k) << (64 * k));
      table_rows.push_back(rw);
    end

    foreach (table_rows[k]) send_contact(table_rows[k].contact, table_rows[k].has_exp,
                                         table_rows[k].exp_outcome);
    idle_input();

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(hcr_pkg::CFG_ELASTICITY, 32'd0); write_reg(hcr_pkg::CFG_DAMPING, 32'd0);
          write_reg(hcr_pkg::CFG_HALT, 32'd0);
        end
        1: begin
          write_reg(hcr_pkg::CFG_ELASTICITY, 32'hffff_ffff);
          write_reg(hcr_pkg::CFG_DAMPING, 32'hffff_ffff);
          write_reg(hcr_pkg::CFG_HALT, 32'hffff_ffff);
        end
        2: begin
          write_reg(hcr_pkg::CFG_ELASTICITY, 32'd32768); write_reg(hcr_pkg::CFG_DAMPING, 32'd32768);
          write_reg(hcr_pkg::CFG_HALT, 32'd1000);
        end
        3: begin
          write_reg(8'd3, $urandom); write_reg(8'd255, $urandom);
          write_reg(hcr_pkg::CFG_DAMPING, 32'd40000); write_reg(hcr_pkg::CFG_HALT, 32'h0010_0000);
        end
        default: begin
          write_reg(hcr_pkg::CFG_ELASTICITY, $urandom); write_reg(hcr_pkg::CFG_DAMPING, $urandom);
          write_reg(hcr_pkg::CFG_HALT, $urandom_range(0, 5000));
        end
      endcase
      for (int k = 0; k < 256; k++) send_contact(rnd_contact(), 1'b0, hcr_pkg::OUT_NONE);
      idle_input();
    end

    out_gap_left = 0;
    drain();
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
